>>> sv/ldfr_pkg.sv
// Shared types and constants of the length-prefixed deframer.
`default_nettype none
package ldfr_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int HEADER_BITS = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PAYLOAD_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EOF_MARKER = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACK_MARKER = 2'd2;

   localparam logic [CSR_DATA_BITS-1:0] MAX_PAYLOAD_LENGTH_RESET = 32'h0001_0000;
   localparam logic [CSR_DATA_BITS-1:0] EOF_MARKER_RESET = 32'hFFFF_FFFF;
   localparam logic [CSR_DATA_BITS-1:0] ACK_MARKER_RESET = 32'hFFFF_FFFE;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_PAYLOAD = 3'd1,
      KIND_EOF     = 3'd2,
      KIND_ACK     = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] max_payload_length;
      logic [CSR_DATA_BITS-1:0] eof_marker;
      logic [CSR_DATA_BITS-1:0] ack_marker;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic       frame_last;
   } result_type;

endpackage
`default_nettype wire

>>> sv/length_prefixed_deframer_top.sv
// Length-prefixed deframer: one stream byte in, one classified result out.
//
// The req_ channel carries one stream byte per transaction; the rsp_ channel
// returns exactly one result per byte: its kind (header, payload, EOF, ACK or
// protocol error), the payload byte and a last-byte flag. Both channels move a
// transaction on a rising edge with valid high and stall low.
// A byte lands in an input register, is decoded combinationally from there
// and its result is registered in the output register; one byte per cycle
// is sustained when rsp_stall stays low. The decode of each byte is a 32-bit
// compare against the maximum length and the two markers plus a 32-bit
// decrement, which sets the cycle time. While the receiver stalls, the output
// register holds its result and the input register holds the next byte;
// req_stall rises once both are full. Reset clears the frame state, empties
// both registers and restores the configuration registers. The user makes
// csr_ writes only while the block is idle; the block does not enforce it.
`default_nettype none
module length_prefixed_deframer_top
   import ldfr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_in_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [2:0]                     rsp_kind,
   output logic [7:0]                     rsp_payload_byte,
   output logic                           rsp_frame_last,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       out_free;
   logic       fire;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   ldfr_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .fire    (fire),
      .in_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_payload_length <= MAX_PAYLOAD_LENGTH_RESET;
         cfg_ff.eof_marker         <= EOF_MARKER_RESET;
         cfg_ff.ack_marker         <= ACK_MARKER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_PAYLOAD_LENGTH: cfg_ff.max_payload_length <= csr_write_data;
            CSR_EOF_MARKER:         cfg_ff.eof_marker         <= csr_write_data;
            CSR_ACK_MARKER:         cfg_ff.ack_marker         <= csr_write_data;
            default:                ; // drop writes to unknown registers
         endcase
      end
   end

   // input register: take a new byte whenever it is empty or the held one moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_frame_last   = out_ff.frame_last;

endmodule
`default_nettype wire

>>> sv/ldfr_decode.sv
// Frame decoder: header gathering, length judging and payload counting.
`default_nettype none
module ldfr_decode
   import ldfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       fire,
   input  wire logic [7:0] in_byte,
   output result_type      result
);

   logic [23:0]            header_bytes_ff, header_bytes_in;
   logic [1:0]             header_count_ff, header_count_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic                   eof_seen_ff, eof_seen_in;
   logic                   ack_seen_ff, ack_seen_in;
   logic                   error_seen_ff, error_seen_in;
   logic [HEADER_BITS-1:0] length;
   logic                   too_wide;

   assign length = {header_bytes_ff, in_byte};
   // upper bits beyond the counter width make the length unusable
   assign too_wide = (length >> LENGTH_BITS) != '0;

   always_comb begin
      header_bytes_in = header_bytes_ff;
      header_count_in = header_count_ff;
      bytes_left_in   = bytes_left_ff;
      eof_seen_in     = eof_seen_ff;
      ack_seen_in     = ack_seen_ff;
      error_seen_in   = error_seen_ff;
      result.kind         = KIND_HEADER;
      result.payload_byte = 8'd0;
      result.frame_last   = 1'b0;
      if (error_seen_ff) begin
         result.kind = KIND_ERROR;
      end else if (bytes_left_ff != '0) begin
         result.kind         = KIND_PAYLOAD;
         result.payload_byte = in_byte;
         result.frame_last   = (bytes_left_ff == LENGTH_BITS'(1));
         bytes_left_in       = bytes_left_ff - LENGTH_BITS'(1);
      end else if (header_count_ff != 2'd3) begin
         header_bytes_in = {header_bytes_ff[15:0], in_byte};
         header_count_in = header_count_ff + 2'd1;
      end else begin
         header_bytes_in = '0;
         header_count_in = '0;
         // markers are checked before the length
         if (length == cfg.eof_marker && !eof_seen_ff) begin
            eof_seen_in = 1'b1;
            result.kind = KIND_EOF;
         end else if (length == cfg.ack_marker && eof_seen_ff && !ack_seen_ff) begin
            ack_seen_in = 1'b1;
            result.kind = KIND_ACK;
         end else if (eof_seen_ff || length == '0 || length > cfg.max_payload_length
                      || too_wide) begin
            error_seen_in = 1'b1;
            result.kind   = KIND_ERROR;
         end else begin
            bytes_left_in = length[LENGTH_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff <= '0;
         header_count_ff <= '0;
         bytes_left_ff   <= '0;
         eof_seen_ff     <= 1'b0;
         ack_seen_ff     <= 1'b0;
         error_seen_ff   <= 1'b0;
      end else if (fire) begin
         header_bytes_ff <= header_bytes_in;
         header_count_ff <= header_count_in;
         bytes_left_ff   <= bytes_left_in;
         eof_seen_ff     <= eof_seen_in;
         ack_seen_ff     <= ack_seen_in;
         error_seen_ff   <= error_seen_in;
      end
   end

endmodule
`default_nettype wire

>>> bench/deframe_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard of the length-prefixed deframer: frame-decode predictor and expected result store.
package deframe_scoreboard_pkg;
   import ldfr_pkg::*;

   class deframe_scoreboard;
      logic [CSR_DATA_BITS-1:0] max_length;
      logic [CSR_DATA_BITS-1:0] eof_code;
      logic [CSR_DATA_BITS-1:0] ack_code;
      logic [23:0]              header_so_far;
      logic [1:0]               header_bytes_held;
      logic [LENGTH_BITS-1:0]   payload_left;
      bit                       eof_flag;
      bit                       ack_flag;
      bit                       error_flag;
      result_type               expected_results[$];
      int                       failures;

      function new();
         max_length = MAX_PAYLOAD_LENGTH_RESET;
         eof_code = EOF_MARKER_RESET;
         ack_code = ACK_MARKER_RESET;
         header_so_far = '0;
         header_bytes_held = '0;
         payload_left = '0;
         eof_flag = 1'b0;
         ack_flag = 1'b0;
         error_flag = 1'b0;
         failures = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_MAX_PAYLOAD_LENGTH: max_length = data;
            CSR_EOF_MARKER: eof_code = data;
            CSR_ACK_MARKER: ack_code = data;
            default: ;
         endcase
      endfunction

      // Markers win over lengths; a marker not accepted now is judged as a length.
      function kind_type classify_header(logic [HEADER_BITS-1:0] word);
         if (word == eof_code && !eof_flag) begin
            eof_flag = 1'b1;
            return KIND_EOF;
         end
         if (word == ack_code && eof_flag && !ack_flag) begin
            ack_flag = 1'b1;
            return KIND_ACK;
         end
         if (eof_flag || word == '0 || word > max_length || (word >> LENGTH_BITS) != '0) begin
            error_flag = 1'b1;
            return KIND_ERROR;
         end
         payload_left = word[LENGTH_BITS-1:0];
         return KIND_HEADER;
      endfunction

      function void note_byte(logic [7:0] in_byte);
         result_type r;
         r.kind = KIND_HEADER;
         r.payload_byte = '0;
         r.frame_last = 1'b0;
         if (error_flag) begin
            r.kind = KIND_ERROR;
         end else if (payload_left != '0) begin
            r.kind = KIND_PAYLOAD;
            r.payload_byte = in_byte;
            r.frame_last = (payload_left == 1);
            payload_left = payload_left - 1'b1;
         end else if (header_bytes_held != 2'd3) begin
            header_so_far = {header_so_far[15:0], in_byte};
            header_bytes_held = header_bytes_held + 1'b1;
         end else begin
            r.kind = classify_header({header_so_far, in_byte});
            header_so_far = '0;
            header_bytes_held = '0;
         end
         expected_results.push_back(r);
      endfunction

      function void check_result(logic [2:0] kind, logic [7:0] payload_byte, logic frame_last);
         result_type want;
         if (expected_results.size() == 0) begin
            $error("result with nothing outstanding: kind %0d", kind);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            failures++;
         end
         if (payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, actual %0h", want.payload_byte, payload_byte);
            failures++;
         end
         if (frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, actual %0d", want.frame_last, frame_last);
            failures++;
         end
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

endpackage

>>> bench/length_prefixed_deframer_top_tb.sv
`timescale 1ns / 100ps
// Testbench of the length-prefixed deframer: framed byte streams under random flow control.
module length_prefixed_deframer_top_tb;
   import ldfr_pkg::*;
   import deframe_scoreboard_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD_CYCLES = 64;

   typedef enum int {
      END_ZERO_LENGTH,
      END_OVER_MAX,
      END_ACK_EARLY,
      END_DATA_AFTER_EOF,
      END_DATA_AFTER_ACK,
      END_EOF_TWICE,
      END_ACK_TWICE
   } stream_end_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_in_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [2:0]                rsp_kind;
   logic [7:0]                rsp_payload_byte;
   logic                      rsp_frame_last;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   deframe_scoreboard sb = new;

   logic [CSR_DATA_BITS-1:0] cur_max = MAX_PAYLOAD_LENGTH_RESET;
   logic [CSR_DATA_BITS-1:0] cur_eof = EOF_MARKER_RESET;
   logic [CSR_DATA_BITS-1:0] cur_ack = ACK_MARKER_RESET;
   int unsigned bytes_sent = 0;
   int unsigned gap_pct = 0;
   int unsigned idle_cycles = 0;
   bit quiet = 1'b0;
   bit long_hold_done = 1'b0;

   always #5 clock = ~clock;

   length_prefixed_deframer_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   task automatic send_byte(input logic [7:0] value);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(value);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [31:0] word);
      for (int i = 3; i >= 0; i--) send_byte(word[8*i +: 8]);
   endtask

   task automatic send_frame(input int unsigned length);
      send_header(length);
      repeat (length) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Keep clear of the EOF code so a data frame never ends the stream.
   function automatic logic [31:0] pick_length(input int unsigned cap);
      logic [31:0] top;
      logic [31:0] length;
      top = (cur_max < cap) ? cur_max : cap;
      do length = $urandom_range(1, top); while (length == cur_eof);
      return length;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      sb.write_register(index, data);
   endtask

   task automatic apply_settings(input logic [31:0] max_len, eof_code, ack_code);
      write_csr(CSR_MAX_PAYLOAD_LENGTH, max_len);
      write_csr(CSR_EOF_MARKER, eof_code);
      write_csr(CSR_ACK_MARKER, ack_code);
      write_csr(CSR_UNUSED, $urandom());
      csr_write_enable <= 1'b0;
      cur_max = max_len;
      cur_eof = eof_code;
      cur_ack = ack_code;
   endtask

   // Check every result transaction; count cycles in which nothing moves.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_kind, rsp_payload_byte, rsp_frame_last);
      if (reset || (rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stall bursts, plus one long hold to fill the block up.
   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!long_hold_done && bytes_sent >= 120) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   initial begin
      logic [31:0] end_max;
      logic [31:0] end_eof;
      logic [31:0] end_ack;
      stream_end_type stream_end;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: shortest frame, then extreme payload values.
      send_header(32'd1);
      send_byte(8'h00);
      send_header(32'd3);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      drain();

      gap_pct = 20;
      while (bytes_sent < 330) send_frame(pick_length(40));
      drain();

      // Smallest maximum; EOF code of zero.
      apply_settings(32'd1, 32'd0, 32'hFFFF_FFFF);
      gap_pct = 0;
      while (bytes_sent < 450) send_frame(1);
      drain();

      // Largest maximum; small ACK code taken as a plain length before EOF.
      apply_settings(32'hFFFF_FFFF, {1'b1, 31'($urandom())}, $urandom_range(1, 30));
      gap_pct = 35;
      send_frame(cur_ack);
      while (bytes_sent < 680) send_frame(pick_length(48));
      drain();

      apply_settings($urandom_range(2, 64), $urandom_range(65, 1000), $urandom());
      gap_pct = 10;
      while (bytes_sent < 880) send_frame(pick_length(64));
      drain();

      // Last part: no idling, then break the stream with a protocol error, some endings after EOF.
      quiet = 1'b1;
      end_max = $urandom_range(8, 63);
      end_eof = $urandom_range(65, 32'hFFFF_FFFE);
      end_ack = $urandom_range(65, 32'hFFFF_FFFE);
      if (end_ack == end_eof)
         end_ack = end_eof + 1;
      apply_settings(end_max, end_eof, end_ack);
      while (bytes_sent < 1000) send_frame(pick_length(cur_max));

      stream_end = stream_end_type'($urandom_range(0, 6));
      case (stream_end)
         END_ZERO_LENGTH: send_header('0);
         END_OVER_MAX: send_header($urandom_range(cur_max + 1, 64));
         END_ACK_EARLY: send_header(cur_ack);
         END_DATA_AFTER_EOF: begin
            send_header(cur_eof);
            send_frame(pick_length(cur_max));
         end
         END_DATA_AFTER_ACK: begin
            send_header(cur_eof);
            send_header(cur_ack);
            send_header(pick_length(cur_max));
         end
         END_EOF_TWICE: begin
            send_header(cur_eof);
            send_header(cur_eof);
         end
         default: begin
            send_header(cur_eof);
            send_header(cur_ack);
            send_header(cur_ack);
         end
      endcase
      // Error is sticky: everything after must answer as an error.
      repeat (24) send_byte(8'($urandom_range(0, 255)));
      drain();

      if (sb.failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
